/* hw/rtl/ivm_pkg.sv */
// ============================================================================
// ivm_pkg: shared types and constants of the vector magnitude pipeline
// Holds the data word carried from stage to stage through the divider and
// multiplier cells.
// ============================================================================
`default_nettype none
package ivm_pkg;

   localparam int unsigned FRAC_BITS = 32;
   localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

   // Data word handed from one cell to the next.
   typedef struct packed {
      logic        valid;
      logic        zero;      // input vector was zero
      logic [63:0] p;
      logic [63:0] q;
      logic [64:0] num;       // dividend or partial remainder
      logic [64:0] den;       // divisor
      logic [32:0] quo;       // quotient bits gathered so far
      logic [32:0] r;         // iteration ratio, Q1.32 (at most one)
   } ivm_beat_type;

endpackage
`default_nettype wire

/* hw/rtl/ivm_div_cell.sv */
// ============================================================================
// ivm_div_cell: one restoring division step
// Shifts the partial remainder, subtracts the divisor when it fits and
// appends one quotient bit; registers the result for the next cell.
// ============================================================================
`default_nettype none
module ivm_div_cell
   import ivm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire ivm_beat_type beat_in,
   output ivm_beat_type      beat_out
);

   ivm_beat_type beat_ff;
   ivm_beat_type beat_in_c;
   logic [65:0]  shifted;

   always_comb begin
      beat_in_c = beat_in;
      shifted   = {beat_in.num, 1'b0};
      beat_in_c.quo = {beat_in.quo[31:0], 1'b0};
      if (shifted >= {1'b0, beat_in.den}) begin
         shifted         = shifted - {1'b0, beat_in.den};
         beat_in_c.quo[0] = 1'b1;
      end
      beat_in_c.num = shifted[64:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff.valid <= 1'b0;
      end else begin
         beat_ff.valid <= beat_in.valid;
      end
      beat_ff.zero <= beat_in_c.zero;
      beat_ff.p    <= beat_in_c.p;
      beat_ff.q    <= beat_in_c.q;
      beat_ff.num  <= beat_in_c.num;
      beat_ff.den  <= beat_in_c.den;
      beat_ff.quo  <= beat_in_c.quo;
      beat_ff.r    <= beat_in_c.r;
   end

   assign beat_out = beat_ff;

endmodule
`default_nettype wire

/* hw/rtl/ivm_iter.sv */
// ============================================================================
// ivm_iter: one pass of the cubically convergent update
// Divider chain for q/p, squaring, divider chain for s/(4+s) on the square s, then the
// p and q updates with the 64x33 products split into 32-bit halves.
// ============================================================================
`default_nettype none
module ivm_iter
   import ivm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire ivm_beat_type beat_in,
   output ivm_beat_type      beat_out
);

   localparam int unsigned NCELL = FRAC_BITS;

   ivm_beat_type d1 [NCELL+1];
   ivm_beat_type d2 [NCELL+1];
   ivm_beat_type setup1_ff, sq_ff, setup2_ff, mlo_ff, mhi_ff, out_ff;
   logic [65:0]  sq_prod;
   logic [65:0]  lo_p, lo_q;
   logic [31:0]  plo_ff, qlo_ff;
   logic [64:0]  hi_p, hi_q;
   logic [32:0]  t_first, s_first;

   // Integer step of the first division: quotient bit one when q is at least p.
   assign d1[0] = setup1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         setup1_ff.valid <= 1'b0;
      end else begin
         setup1_ff.valid <= beat_in.valid;
      end
      setup1_ff.zero <= beat_in.zero;
      setup1_ff.p    <= beat_in.p;
      setup1_ff.q    <= beat_in.q;
      setup1_ff.den  <= {1'b0, beat_in.p};
      setup1_ff.r    <= beat_in.r;
      if (beat_in.q >= beat_in.p) begin
         setup1_ff.quo <= 33'd1;
         setup1_ff.num <= {1'b0, beat_in.q - beat_in.p};
      end else begin
         setup1_ff.quo <= 33'd0;
         setup1_ff.num <= {1'b0, beat_in.q};
      end
   end

   for (genvar i = 0; i < NCELL; i++) begin : g_div1
      ivm_div_cell u_cell (.clock(clock), .reset(reset), .beat_in(d1[i]),
         .beat_out(d1[i+1]));
   end

   // Square of the ratio.
   assign t_first = d1[NCELL].quo;
   assign sq_prod = {33'd0, t_first} * {33'd0, t_first};
   always_comb begin
      s_first = t_first[32] ? ONE_Q32 : sq_prod[64:32];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_ff.valid <= 1'b0;
      end else begin
         sq_ff.valid <= d1[NCELL].valid;
      end
      sq_ff.zero <= d1[NCELL].zero;
      sq_ff.p    <= d1[NCELL].p;
      sq_ff.q    <= d1[NCELL].q;
      sq_ff.num  <= {32'd0, s_first};
      sq_ff.den  <= 65'd0;
      sq_ff.quo  <= 33'd0;
      sq_ff.r    <= 33'd0;
   end

   // Second division: s / (4 + s); s is below the divisor so no integer bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         setup2_ff.valid <= 1'b0;
      end else begin
         setup2_ff.valid <= sq_ff.valid;
      end
      setup2_ff.zero <= sq_ff.zero;
      setup2_ff.p    <= sq_ff.p;
      setup2_ff.q    <= sq_ff.q;
      setup2_ff.num  <= sq_ff.num;
      setup2_ff.den  <= {30'd0, 35'h4_0000_0000} + sq_ff.num;
      setup2_ff.quo  <= 33'd0;
      setup2_ff.r    <= 33'd0;
   end

   assign d2[0] = setup2_ff;

   for (genvar i = 0; i < NCELL; i++) begin : g_div2
      ivm_div_cell u_cell (.clock(clock), .reset(reset), .beat_in(d2[i]),
         .beat_out(d2[i+1]));
   end

   // Low halves of p*r and q*r.
   assign lo_p = {34'd0, d2[NCELL].p[31:0]} * {33'd0, d2[NCELL].quo};
   assign lo_q = {34'd0, d2[NCELL].q[31:0]} * {33'd0, d2[NCELL].quo};

   always_ff @(posedge clock) begin
      if (reset) begin
         mlo_ff.valid <= 1'b0;
      end else begin
         mlo_ff.valid <= d2[NCELL].valid;
      end
      mlo_ff.zero <= d2[NCELL].zero;
      mlo_ff.p    <= d2[NCELL].p;
      mlo_ff.q    <= d2[NCELL].q;
      mlo_ff.num  <= 65'd0;
      mlo_ff.den  <= 65'd0;
      mlo_ff.quo  <= 33'd0;
      mlo_ff.r    <= d2[NCELL].quo;
      plo_ff      <= lo_p[63:32];
      qlo_ff      <= lo_q[63:32];
   end

   // High halves and the updates.
   assign hi_p = {1'b0, mlo_ff.p[63:32]} * mlo_ff.r;
   assign hi_q = {1'b0, mlo_ff.q[63:32]} * mlo_ff.r;

   always_ff @(posedge clock) begin
      if (reset) begin
         mhi_ff.valid <= 1'b0;
      end else begin
         mhi_ff.valid <= mlo_ff.valid;
      end
      mhi_ff.zero <= mlo_ff.zero;
      mhi_ff.p    <= mlo_ff.p;
      mhi_ff.q    <= mlo_ff.q;
      mhi_ff.num  <= hi_p + {33'd0, plo_ff};
      mhi_ff.den  <= hi_q + {33'd0, qlo_ff};
      mhi_ff.quo  <= 33'd0;
      mhi_ff.r    <= mlo_ff.r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else begin
         out_ff.valid <= mhi_ff.valid;
      end
      out_ff.zero <= mhi_ff.zero;
      out_ff.p    <= mhi_ff.p + {mhi_ff.num[62:0], 1'b0};
      out_ff.q    <= mhi_ff.den[63:0];
      out_ff.num  <= 65'd0;
      out_ff.den  <= 65'd0;
      out_ff.quo  <= 33'd0;
      out_ff.r    <= 33'd0;
   end

   assign beat_out = out_ff;

endmodule
`default_nettype wire

/* hw/rtl/iterative_vector_magnitude.sv */
// ============================================================================
// iterative_vector_magnitude: pipelined Pythagorean sum
// Returns sqrt(a^2+b^2) of two signed Q16.16 components as unsigned Q16.16.
// ============================================================================
// Usage:
//   Drive req_coord_a and req_coord_b and raise start; a beat is taken at
//   every clock edge where start is high and busy is low. busy is always low,
//   so a new beat can enter every cycle.
//   Each beat yields one result: rsp_magnitude is shown for one cycle with
//   rsp_valid high, in the order the beats came in. The receiver must take it
//   then; there is no stall.
//   Each pass has two 32-cell divider chains plus six register stages; an entry
//   register and an output register sit around the passes. Throughput is one beat per cycle.
//   Zero vectors follow the same path and return zero.
//   Synchronous reset drops every beat in flight; no results appear for them.
// ============================================================================
`default_nettype none
module iterative_vector_magnitude
   import ivm_pkg::*;
#(
   parameter int unsigned ITERATIONS = 3
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [31:0] req_coord_a,
   input  wire logic [31:0] req_coord_b,
   output logic             rsp_valid,
   output logic [31:0]      rsp_magnitude
);

   ivm_beat_type stage [ITERATIONS+1];
   ivm_beat_type entry_ff;
   logic [31:0]  abs_a, abs_b;
   logic [31:0]  rsp_magnitude_ff;
   logic         rsp_valid_ff;

   assign busy  = 1'b0;
   assign abs_a = req_coord_a[31] ? (~req_coord_a + 32'd1) : req_coord_a;
   assign abs_b = req_coord_b[31] ? (~req_coord_b + 32'd1) : req_coord_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= start;
      end
      if (abs_a >= abs_b) begin
         entry_ff.p <= {abs_a, 32'd0};
         entry_ff.q <= {abs_b, 32'd0};
      end else begin
         entry_ff.p <= {abs_b, 32'd0};
         entry_ff.q <= {abs_a, 32'd0};
      end
      entry_ff.zero <= (abs_a == 32'd0) && (abs_b == 32'd0);
      entry_ff.num  <= 65'd0;
      entry_ff.den  <= 65'd0;
      entry_ff.quo  <= 33'd0;
      entry_ff.r    <= 33'd0;
   end

   assign stage[0] = entry_ff;

   for (genvar k = 0; k < ITERATIONS; k++) begin : g_iter
      ivm_iter u_iter (.clock(clock), .reset(reset), .beat_in(stage[k]),
         .beat_out(stage[k+1]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= stage[ITERATIONS].valid;
      end
      rsp_magnitude_ff <= stage[ITERATIONS].zero ? 32'd0 : stage[ITERATIONS].p[63:32];
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_magnitude = rsp_magnitude_ff;

endmodule
`default_nettype wire

/* hw/rtl/ivm_checker.sv */
// ============================================================================
// ivm_checker: port-level checks of the vector magnitude block
// Watches the ports of the top level over time.
// ============================================================================
`default_nettype none
module ivm_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic [31:0] req_coord_a,
   input wire logic [31:0] req_coord_b,
   input wire logic        rsp_valid,
   input wire logic [31:0] rsp_magnitude
);

   // The block never refuses a beat.
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   // No result leaves in the cycle after reset.
   a_quiet_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result right after reset");

   // The result never exceeds sqrt(2) times full scale.
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_magnitude <= 32'hB504_F334)
      else $error("magnitude out of range");

endmodule

bind iterative_vector_magnitude ivm_checker u_ivm_checker (.*);
`default_nettype wire
